// ===== rtl/tllc_pkg.sv =====
`default_nettype none
package tllc_pkg;
    localparam logic [7:0] C_BEL = 8'd7;
    localparam logic [7:0] C_BS  = 8'd8;
    localparam logic [7:0] C_LF  = 8'd10;
    localparam logic [7:0] C_CR  = 8'd13;
    localparam logic [7:0] C_ESC = 8'd27;
    localparam logic [7:0] C_SP  = 8'd32;
    localparam logic [7:0] C_CARET = 8'd94;
    localparam logic [7:0] C_LBR = 8'd91;
    localparam logic [7:0] C_RBR = 8'd93;
    localparam logic [7:0] C_P   = 8'd80;
    localparam logic [7:0] C_AT  = 8'd64;
    localparam logic [7:0] C_A   = 8'd65;
    localparam logic [7:0] C_0   = 8'd48;
    localparam logic [7:0] C_1   = 8'd49;
    localparam logic [7:0] C_9   = 8'd57;
    localparam logic [7:0] C_SEMI = 8'd59;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_LEN  = 2'd1;
    localparam logic [1:0] OP_LINE = 2'd2;
    localparam logic [1:0] OP_CTL  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [1:0]  len_mode;
        logic [13:0] amount;
    } t_cmd;

    localparam logic [1:0] LM_CLEAR = 2'd0;
    localparam logic [1:0] LM_DEC   = 2'd1;
    localparam logic [1:0] LM_TWO   = 2'd2;
    localparam logic [1:0] LM_SUB   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/tllc_front.sv =====
`default_nettype none
module tllc_front
    import tllc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_byte,
    output logic       o_cmd_valid,
    input  wire        i_cmd_ready,
    output t_cmd       o_cmd
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PARAM = 2'd1;
    localparam logic [1:0] PH_COLOUR = 2'd2;
    localparam logic [1:0] PH_OSC = 2'd3;

    logic [1:0]  r_ph, n_ph;
    logic        r_ret, n_ret, r_esc, n_esc, r_osc, n_osc;
    logic [2:0]  r_dig, n_dig;
    logic [13:0] r_num, n_num;
    logic [7:0]  r_fb, n_fb, r_sb, n_sb;
    logic [1:0]  r_skip, n_skip;
    logic        r_pv, n_pv;
    t_cmd        r_pc, n_pc;
    logic        hit, clr, emit;
    t_cmd        cmd;
    logic [1:0]  sk;
    logic [13:0] num10;

    assign o_ready = !r_pv || i_cmd_ready;
    assign o_cmd_valid = r_pv;
    assign o_cmd = r_pc;
    assign hit = i_valid && o_ready;
    assign num10 = 14'((r_num << 3) + (r_num << 1) + 14'(i_byte - C_0));

    always_comb begin
        n_ph = r_ph; n_ret = r_ret; n_esc = r_esc; n_osc = r_osc; n_dig = r_dig;
        n_num = r_num; n_fb = r_fb; n_sb = r_sb; n_skip = r_skip;
        emit = 1'b0; clr = 1'b0; sk = 2'd0;
        cmd = '{op: OP_PUT, data: i_byte, len_mode: LM_CLEAR, amount: 14'd0};
        if (r_ph == PH_PARAM) begin
            if (r_dig < 3'd4 && i_byte >= C_0 && i_byte <= C_9) begin
                n_num = num10;
                if (r_dig == 3'd0) n_fb = i_byte;
                if (r_dig == 3'd1) n_sb = i_byte;
                n_dig = r_dig + 3'd1;
            end else begin
                if (r_dig == 3'd0) n_fb = i_byte;
                if (r_dig == 3'd1) n_sb = i_byte;
                if (r_osc) begin
                    n_ph = PH_OSC;
                    if (r_dig == 3'd0 && i_byte == C_A) begin
                        emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_TWO;
                    end
                end else if (r_dig == 3'd2 && r_fb == C_0 && r_sb == C_1
                             && i_byte == C_SEMI) begin
                    n_ph = PH_COLOUR; n_skip = 2'd3;
                end else begin
                    n_ph = PH_IDLE;
                    if (r_dig == 3'd0 && i_byte == C_A) begin
                        emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_TWO;
                    end else if (i_byte == C_P) begin
                        emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_SUB;
                        cmd.amount = r_num;
                    end else if (i_byte == C_AT) begin
                        emit = 1'b1; cmd.data = C_SP;
                    end
                end
            end
        end else if (r_ph == PH_COLOUR) begin
            sk = (r_skip != 2'd0) ? r_skip - 2'd1 : 2'd0;
            n_skip = sk;
            if (sk == 2'd0) begin
                n_ph = PH_IDLE;
                if (i_byte == C_P) begin
                    emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_SUB;
                    cmd.amount = 14'd1;
                end else if (i_byte == C_AT) begin
                    emit = 1'b1; cmd.data = C_SP;
                end
            end
        end else if (r_ph == PH_OSC) begin
            if (i_byte <= C_BEL) n_ph = PH_IDLE;
        end else begin
            clr = r_ret && i_byte != C_LF;
            n_ret = 1'b0;
            if (i_byte < C_SP) begin
                n_esc = 1'b0;
                case (i_byte)
                    C_BS: begin
                        emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_DEC;
                    end
                    C_LF: begin
                        emit = 1'b1; cmd.op = OP_LINE;
                    end
                    C_CR: n_ret = 1'b1;
                    C_BEL: ;
                    C_ESC: n_esc = 1'b1;
                    default: begin
                        emit = 1'b1; cmd.op = OP_CTL;
                    end
                endcase
            end else if (r_esc && (i_byte == C_LBR || i_byte == C_RBR)) begin
                n_osc = (i_byte == C_RBR); n_ph = PH_PARAM; n_dig = 3'd0;
                n_num = 14'd0; n_fb = 8'd0; n_sb = 8'd0; n_skip = 2'd0;
            end else begin
                emit = 1'b1;
            end
        end
        // carriage-return restart folds into the command
        if (clr) begin
            cmd.len_mode = (cmd.op == OP_LEN && cmd.len_mode == LM_DEC) ? LM_CLEAR
                         : cmd.len_mode;
            if (!emit) begin
                emit = 1'b1; cmd.op = OP_LEN; cmd.len_mode = LM_CLEAR;
            end else if (cmd.op != OP_LEN) begin
                cmd.amount = 14'h3fff;
            end
        end
        n_pv = r_pv && !i_cmd_ready;
        n_pc = r_pc;
        if (hit) begin
            n_pv = emit;
            n_pc = cmd;
        end else begin
            n_ph = r_ph; n_ret = r_ret; n_esc = r_esc; n_osc = r_osc; n_dig = r_dig;
            n_num = r_num; n_fb = r_fb; n_sb = r_sb; n_skip = r_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_ret <= 1'b0; r_esc <= 1'b0; r_osc <= 1'b0;
            r_dig <= 3'd0; r_num <= 14'd0; r_fb <= 8'd0; r_sb <= 8'd0;
            r_skip <= 2'd0; r_pv <= 1'b0;
        end else begin
            r_ph <= n_ph; r_ret <= n_ret; r_esc <= n_esc; r_osc <= n_osc;
            r_dig <= n_dig; r_num <= n_num; r_fb <= n_fb; r_sb <= n_sb;
            r_skip <= n_skip; r_pv <= n_pv;
        end
        r_pc <= n_pc;
    end
endmodule
`default_nettype wire

// ===== rtl/tllc_back.sv =====
`default_nettype none
module tllc_back
    import tllc_pkg::*;
#(
    parameter int LINE_CHARS = 63
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_char,
    output logic       o_end,
    output logic       o_trunc
);
    localparam int AW = $clog2(LINE_CHARS + 1);
    localparam logic [AW-1:0] FULL = AW'(LINE_CHARS);

    localparam logic [2:0] S_CMD = 3'd0;
    localparam logic [2:0] S_C1  = 3'd1;
    localparam logic [2:0] S_C2  = 3'd2;
    localparam logic [2:0] S_RD  = 3'd3;
    localparam logic [2:0] S_CHK = 3'd4;
    localparam logic [2:0] S_END = 3'd5;

    logic [7:0]    mem [LINE_CHARS];
    logic [LINE_CHARS-1:0] r_vld;
    logic [2:0]    r_st, n_st;
    logic [AW-1:0] r_len, n_len, r_k, n_k, len0;
    logic          r_drop, n_drop;
    logic [7:0]    r_ctl, r_rd;
    logic          r_rvld;
    logic          r_ov, n_ov, r_oend, n_oend, r_otr, n_otr;
    logic [7:0]    r_och, n_och;
    logic          we, out_free, take;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [7:0]    rdv;

    assign out_free = !r_ov || i_ready;
    assign o_valid = r_ov; assign o_char = r_och; assign o_end = r_oend;
    assign o_trunc = r_otr;
    assign o_cmd_ready = (r_st == S_CMD) && out_free;
    assign take = i_cmd_valid && o_cmd_ready;
    assign len0 = (i_cmd.amount == 14'h3fff || (i_cmd.op == OP_LEN
                   && i_cmd.len_mode == LM_CLEAR)) ? '0 : r_len;
    assign rdv = r_rvld ? r_rd : 8'd0;

    always_comb begin
        n_st = r_st; n_len = r_len; n_k = r_k; n_drop = r_drop;
        n_ov = r_ov && !i_ready; n_och = r_och; n_oend = r_oend; n_otr = r_otr;
        we = 1'b0; wa = r_len; wd = i_cmd.data;
        case (r_st)
            S_CMD: if (take) begin
                case (i_cmd.op)
                    OP_PUT: begin
                        n_len = len0; wa = len0;
                        if (len0 < FULL) begin we = 1'b1; n_len = len0 + 1'b1; end
                        else n_drop = 1'b1;
                    end
                    OP_CTL: begin
                        n_len = len0; wa = len0; wd = C_CARET;
                        if (len0 < FULL) begin we = 1'b1; n_len = len0 + 1'b1; end
                        else n_drop = 1'b1;
                        n_st = S_C1;
                    end
                    OP_LINE: begin
                        n_k = '0; n_st = S_RD;
                    end
                    default: begin
                        case (i_cmd.len_mode)
                            LM_DEC: n_len = (r_len != '0) ? r_len - 1'b1 : '0;
                            LM_TWO: n_len = AW'(2);
                            LM_SUB: n_len = (i_cmd.amount >= 14'(r_len)) ? '0
                                          : r_len - AW'(i_cmd.amount);
                            default: n_len = '0;
                        endcase
                    end
                endcase
            end
            S_C1, S_C2: begin
                wd = (r_st == S_C1) ? r_ctl + C_AT : r_ctl;
                if (r_len < FULL) begin we = 1'b1; n_len = r_len + 1'b1; end
                else n_drop = 1'b1;
                n_st = (r_st == S_C1) ? S_C2 : S_CMD;
            end
            S_RD: begin
                if (r_k < r_len) n_st = S_CHK;
                else n_st = S_END;
            end
            S_CHK: if (out_free) begin
                if (rdv == 8'd0) n_st = S_END;
                else begin
                    n_ov = 1'b1; n_och = rdv; n_oend = 1'b0; n_otr = 1'b0;
                    n_k = r_k + 1'b1; n_st = S_RD;
                end
            end
            S_END: if (out_free) begin
                n_ov = 1'b1; n_och = C_LF; n_oend = 1'b1; n_otr = r_drop;
                if (r_len < FULL) begin we = 1'b1; wa = r_len; wd = 8'd0; end
                n_len = '0; n_drop = 1'b0; n_st = S_CMD;
            end
            default: n_st = S_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CMD; r_len <= '0; r_k <= '0; r_drop <= 1'b0;
            r_ov <= 1'b0; r_vld <= '0;
        end else begin
            r_st <= n_st; r_len <= n_len; r_k <= n_k; r_drop <= n_drop;
            r_ov <= n_ov;
            if (we) r_vld[wa[AW-1:0]] <= 1'b1;
        end
        if (take) r_ctl <= i_cmd.data;
        r_och <= n_och; r_oend <= n_oend; r_otr <= n_otr;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[r_k[AW-1:0]];
        r_rvld <= r_vld[r_k];
    end
endmodule
`default_nettype wire

// ===== rtl/terminal_log_line_cleaner_top.sv =====
// Ordinary bytes are registered as a command in the front decoder, then written to the line by the engine.
// Control bytes that store three characters hold the engine while it writes the caret, letter and byte.
// A line feed holds the engine while it steps through S_RD and S_CHK for each emitted character and
// then S_END (a zero byte ends the line early), and longer while the output stalls.
// Input is taken each cycle while the one-entry command queue can drain.
// Synchronous active-low reset empties the line and closes any open sequence;
// stored bytes are marked empty by per-entry valid bits cleared at reset.
`default_nettype none
module terminal_log_line_cleaner_top
    import tllc_pkg::*;
#(
    parameter int LINE_CHARS = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char
    output logic        m_axis_tlast,   // line_end
    output logic        m_axis_tuser    // line_truncated
);
    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    tllc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_byte(s_axis_tdata),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    tllc_back #(.LINE_CHARS(LINE_CHARS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_char(m_axis_tdata),
        .o_end(m_axis_tlast), .o_trunc(m_axis_tuser)
    );
endmodule
`default_nettype wire

// ===== dv/terminal_log_line_cleaner_checker.sv =====
`default_nettype none
module terminal_log_line_cleaner_checker
    import tllc_pkg::*;
#(
    parameter int LINE_CHARS = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_in_data,     // in_byte
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [7:0]  i_out_data,    // out_char
    input  wire         i_out_last,    // line_end
    input  wire         i_out_user,    // line_truncated
    output int          o_fail_count,
    output int          o_pending
);
    typedef enum int {SEQ_IDLE, SEQ_PARAM, SEQ_COLOUR, SEQ_OSC} t_seq;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_char_item;

    t_char_item expected_chars[$];

    logic [7:0] line_buf[LINE_CHARS];
    int         line_len;
    bit         cr_seen;
    bit         esc_seen;
    t_seq       seq;
    int         ndigits;
    int         rep;
    logic [7:0] seq_b0;
    logic [7:0] seq_b1;
    int         colour_left;
    bit         is_osc;
    bit         overflowed;

    task automatic append(input logic [7:0] b);
        if (line_len < LINE_CHARS) begin
            line_buf[line_len] = b;
            line_len++;
        end else begin
            overflowed = 1;
        end
    endtask

    task automatic finish_seq(input logic [7:0] b);
        if (b == C_P) begin
            if (rep >= line_len) line_len = 0;
            else line_len -= rep;
        end else if (b == C_AT) begin
            append(C_SP);
        end
    endtask

    task automatic seq_step(input logic [7:0] b);
        int i;
        i = ndigits;
        if (seq == SEQ_PARAM) begin
            if (i < 4 && b >= C_0 && b <= C_9) begin
                rep = rep * 10 + (b - C_0);
                if (i == 0) seq_b0 = b;
                if (i == 1) seq_b1 = b;
                ndigits = i + 1;
                return;
            end
            if (i == 0) seq_b0 = b;
            if (i == 1) seq_b1 = b;
            if (is_osc) begin
                if (i == 0 && b == C_A) line_len = 2;
                seq = SEQ_OSC;
                return;
            end
            if (i == 2 && seq_b0 == C_0 && seq_b1 == C_1 && b == C_SEMI) begin
                seq = SEQ_COLOUR;
                colour_left = 3;
                return;
            end
            finish_seq(b);
            if (i == 0 && b == C_A) line_len = 2;
            seq = SEQ_IDLE;
        end else if (seq == SEQ_COLOUR) begin
            if (colour_left > 0) colour_left--;
            if (colour_left == 0) begin
                finish_seq(b);
                seq = SEQ_IDLE;
            end
        end else if (b <= C_BEL) begin
            seq = SEQ_IDLE;
        end
    endtask

    task automatic clean_byte(input logic [7:0] c);
        t_char_item it;
        if (seq != SEQ_IDLE) begin
            seq_step(c);
            return;
        end
        if (cr_seen && c != C_LF) line_len = 0;
        cr_seen = 0;
        if (c < C_SP) begin
            esc_seen = 0;
            case (c)
                C_BS: if (line_len > 0) line_len--;
                C_LF: begin
                    for (int k = 0; k < line_len; k++) begin
                        if (line_buf[k] == 8'd0) break;
                        it = '{ch: line_buf[k], last: 1'b0, trunc: 1'b0};
                        expected_chars.push_back(it);
                    end
                    it = '{ch: C_LF, last: 1'b1, trunc: overflowed};
                    expected_chars.push_back(it);
                    if (line_len < LINE_CHARS) line_buf[line_len] = 8'd0;
                    line_len = 0;
                    overflowed = 0;
                end
                C_CR:  cr_seen = 1;
                C_BEL: ;
                C_ESC: esc_seen = 1;
                default: begin
                    append(C_CARET);
                    append(c + 8'd64);
                    append(c);
                end
            endcase
        end else if (esc_seen && (c == C_LBR || c == C_RBR)) begin
            is_osc = (c == C_RBR);
            seq = SEQ_PARAM;
            ndigits = 0;
            rep = 0;
            seq_b0 = 0;
            seq_b1 = 0;
            colour_left = 0;
        end else begin
            append(c);
        end
    endtask

    assign o_pending = expected_chars.size();

    always @(posedge i_clk) begin
        t_char_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_CHARS; k++) line_buf[k] = 8'd0;
            line_len = 0;
            cr_seen = 0;
            esc_seen = 0;
            seq = SEQ_IDLE;
            ndigits = 0;
            rep = 0;
            seq_b0 = 0;
            seq_b1 = 0;
            colour_left = 0;
            is_osc = 0;
            overflowed = 0;
            expected_chars.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected item char=%0d last=%0b trunc=%0b",
                             $time, i_out_data, i_out_last, i_out_user);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== i_out_data || want.last !== i_out_last ||
                        want.trunc !== i_out_user) begin
                        $display("%0t: mismatch expected char=%0d last=%0b trunc=%0b, %s",
                                 $time, want.ch, want.last, want.trunc,
                                 $sformatf("actual char=%0d last=%0b trunc=%0b",
                                           i_out_data, i_out_last, i_out_user));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) clean_byte(i_in_data);
        end
    end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
    import tllc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       s_axis_tvalid = 0;
    logic [7:0] s_axis_tdata = 0;   // in_byte
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 0;
    logic [7:0] m_axis_tdata;       // out_char
    logic       m_axis_tlast;       // line_end
    logic       m_axis_tuser;       // line_truncated
    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         sent = 0;
    int         lines_seen = 0;
    int         idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    terminal_log_line_cleaner_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    terminal_log_line_cleaner_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (m_axis_tvalid && m_axis_tready && m_axis_tlast) lines_seen++;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(input int n);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic send_random_chunk();
        logic [7:0] fin[7];
        int n;
        fin = '{C_P, C_AT, C_A, 8'd74, 8'd72, 8'd77, 8'd0};
        case ($urandom_range(11))
            0, 1: send_text($urandom_range(1, 8));
            2: send_text($urandom_range(60, 70));
            3, 4: send_byte(C_LF);
            5: begin
                send_byte(C_CR);
                if ($urandom_range(1)) send_byte(C_LF); else send_text(3);
            end
            6: send_byte($urandom_range(1) ? C_BS : C_BEL);
            7: begin
                send_byte(C_ESC);
                send_byte(C_LBR);
                n = $urandom_range(5);
                for (int k = 0; k < n; k++) send_byte(8'($urandom_range(C_0, C_9)));
                fin[6] = 8'($urandom);
                send_byte(fin[$urandom_range(6)]);
            end
            8: begin
                send_byte(C_ESC);
                send_byte(C_LBR);
                send_byte(C_0);
                send_byte(C_1);
                send_byte(C_SEMI);
                send_text(2);
                send_byte($urandom_range(1) ? C_P : C_AT);
            end
            9: begin
                send_byte(C_ESC);
                send_byte(C_RBR);
                if ($urandom_range(1)) send_byte(C_A);
                send_text($urandom_range(4));
                send_byte(8'($urandom_range(7)));
            end
            10: send_byte(8'($urandom_range(31)));
            default: send_byte(8'($urandom));
        endcase
    endtask

    initial begin
        int idle_pct[4];
        int stall_pct[4];
        idle_pct  = '{0, 81, 0, 21};
        stall_pct = '{0, 0, 81, 21};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: edges of the byte, backspace at empty, controls, P, @ and OSC sequences
        send_byte(8'd97); send_byte(C_BS); send_byte(C_BS); send_byte(8'd127);
        send_byte(8'd255); send_byte(8'd128); send_byte(8'd1); send_byte(8'd0);
        send_byte(8'd66); send_byte(C_BEL); send_byte(C_LF);
        send_text(5); send_byte(C_ESC); send_byte(C_LBR); send_byte(C_1);
        send_byte(C_9); send_byte(C_P); send_byte(C_ESC); send_byte(C_LBR);
        send_byte(C_AT); send_byte(C_CR); send_byte(8'd113); send_byte(C_LF);
        send_byte(C_ESC); send_byte(C_RBR); send_byte(C_A); send_byte(C_BEL);
        send_byte(C_LF);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            while (sent < 30 + (ph + 1) * 75) send_random_chunk();
            send_byte(C_LF);
            s_axis_tvalid <= 0;
            wait (pending == 0);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 0;
        recv_stall_pct = 0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d bytes over four idle/stall phases; %0d lines checked.",
                 sent, lines_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
